>>> hdl/cpe_pkg.sv
// Shared types, constants and codes for the choice path enumerator.
// Used by the enumerator, its divider and the testbench; depends on nothing else.
package cpe_pkg;

  localparam int STACK_DEPTH  = 16;
  localparam int MAX_OPTIONS  = 256;
  localparam int WEIGHTED_MAX = 8;

  localparam int KIND_W    = 3;
  localparam int OPT_W     = 8;
  localparam int CNT_W     = 9;
  localparam int PROB_W    = 17;
  localparam int PROB_FRAC = 16;
  localparam int STATUS_W  = 2;

  localparam int IDX_W  = $clog2(STACK_DEPTH);
  localparam int SIZE_W = $clog2(STACK_DEPTH + 1);
  localparam int WSEL_W = $clog2(WEIGHTED_MAX);

  // Step counter of the divider and the product after dropping its fraction bits.
  localparam int DIV_STEP_W = $clog2(PROB_W + 1);
  localparam int MUL_SH_W   = 2 * PROB_W - PROB_FRAC;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 32;

  localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN    = 3'd0,
    KIND_NEXT     = 3'd1,
    KIND_UNIFORM  = 3'd2,
    KIND_WEIGHTED = 3'd3,
    KIND_FINISH   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_MISMATCH  = 2'd2,
    ST_BAD_COUNT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PREV_RD,
    S_PREV_CAP,
    S_SEL,
    S_REP_CAP,
    S_PROB,
    S_MUL,
    S_WR,
    S_POP_RD,
    S_POP_CHK,
    S_FIN_RD,
    S_FIN_CAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OPT_W-1:0]  opt;
    logic [CNT_W-1:0]  cnt;
    logic [PROB_W-1:0] prob;
  } entry_t;

endpackage

>>> hdl/choice_path_enumerator.sv
// A uniform choose that forms a probability waits for the iterative 1/n divider. One item at a
// time: s_tready is high only while idle, so a new item is taken only after the last one is
// finished; a result waits for m_tready.
// Synchronous reset empties the stack, clears replay depth, first-path flag and m_tvalid.
module choice_path_enumerator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // option_count, option_prob_0 .. option_prob_7, zero pad
  input  logic [cpe_pkg::IN_DATA_W-1:0] s_tdata,
  // kind
  input  logic [cpe_pkg::KIND_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // chosen_option, path_available, step_probability, status, zero pad
  output logic [cpe_pkg::OUT_DATA_W-1:0] m_tdata
);

  cpe_pkg::state_t state, state_next;
  cpe_pkg::kind_t  kind;

  logic [cpe_pkg::CNT_W-1:0]  n;
  logic [cpe_pkg::PROB_W-1:0] probs [cpe_pkg::WEIGHTED_MAX];

  logic [cpe_pkg::SIZE_W-1:0] size;
  logic [cpe_pkg::SIZE_W-1:0] rd_p1;    // replay depth plus one
  logic                       first_flag;

  logic [cpe_pkg::PROB_W-1:0] prev;
  logic [cpe_pkg::OPT_W-1:0]  idx;
  logic [cpe_pkg::CNT_W-1:0]  keep_cnt;
  logic [cpe_pkg::IDX_W-1:0]  widx;
  logic [cpe_pkg::PROB_W-1:0] factor;
  logic [cpe_pkg::PROB_W-1:0] prod;

  logic [cpe_pkg::OPT_W-1:0]    r_chosen;
  logic                         r_avail;
  logic [cpe_pkg::PROB_W-1:0]   r_prob;
  cpe_pkg::status_t             r_status;

  logic                         ram_we;
  logic [cpe_pkg::IDX_W-1:0]    ram_waddr;
  cpe_pkg::entry_t              ram_wdata;
  logic [cpe_pkg::IDX_W-1:0]    ram_raddr;
  logic [$bits(cpe_pkg::entry_t)-1:0] ram_rdata;
  cpe_pkg::entry_t              rd;

  logic                         div_start;
  logic                         div_busy;
  logic [cpe_pkg::PROB_W-1:0]   div_q;

  logic                         bad_count;
  logic                         prev_hit;
  logic                         full;
  logic                         pop_adv;
  logic [cpe_pkg::IDX_W-1:0]    top_idx;
  logic [cpe_pkg::PROB_W-1:0]   wsel;
  logic                         w_ok;
  logic [cpe_pkg::PROB_W-1:0]   wfactor;
  logic [2*cpe_pkg::PROB_W-1:0] product;
  logic [cpe_pkg::MUL_SH_W-1:0] shifted;
  logic                         out_free;

  cpe_ram #(
    .WIDTH ($bits(cpe_pkg::entry_t)),
    .DEPTH (cpe_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cpe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cpe_pkg::PROB_ONE),
    .divisor  (n),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign rd       = cpe_pkg::entry_t'(ram_rdata);
  assign s_tready = state == cpe_pkg::S_IDLE;
  assign out_free = !m_tvalid || m_tready;

  assign bad_count = (n == '0) ||
                     ((kind == cpe_pkg::KIND_WEIGHTED) ?
                      (32'(n) > 32'(cpe_pkg::WEIGHTED_MAX)) :
                      (32'(n) > 32'(cpe_pkg::MAX_OPTIONS)));
  assign prev_hit  = (rd_p1 != '0) && (rd_p1 <= size);
  assign full      = size == cpe_pkg::SIZE_W'(cpe_pkg::STACK_DEPTH);
  assign top_idx   = cpe_pkg::IDX_W'(size - 1'b1);
  assign pop_adv   = rd.cnt > (cpe_pkg::CNT_W'(rd.opt) + 1'b1);

  // A weighted option outside the count or the probability list weighs zero.
  assign wsel    = probs[idx[cpe_pkg::WSEL_W-1:0]];
  assign w_ok    = (cpe_pkg::CNT_W'(idx) < n) &&
                   (idx < cpe_pkg::OPT_W'(cpe_pkg::WEIGHTED_MAX));
  assign wfactor = w_ok ? ((wsel > cpe_pkg::PROB_ONE) ? cpe_pkg::PROB_ONE : wsel) : '0;

  assign product = factor * prev;
  assign shifted = product[2*cpe_pkg::PROB_W-1:cpe_pkg::PROB_FRAC];

  always_comb begin
    state_next = state;
    case (state)
      cpe_pkg::S_IDLE: begin
        if (s_tvalid) state_next = cpe_pkg::S_DECODE;
      end
      cpe_pkg::S_DECODE: begin
        case (kind)
          cpe_pkg::KIND_NEXT: begin
            state_next = first_flag ? cpe_pkg::S_DONE : cpe_pkg::S_POP_RD;
          end
          cpe_pkg::KIND_UNIFORM, cpe_pkg::KIND_WEIGHTED: begin
            if (bad_count) state_next = cpe_pkg::S_DONE;
            else if (prev_hit) state_next = cpe_pkg::S_PREV_RD;
            else state_next = cpe_pkg::S_SEL;
          end
          cpe_pkg::KIND_FINISH: begin
            state_next = (size != '0) ? cpe_pkg::S_FIN_RD : cpe_pkg::S_DONE;
          end
          default: state_next = cpe_pkg::S_DONE;
        endcase
      end
      cpe_pkg::S_PREV_RD:  state_next = cpe_pkg::S_PREV_CAP;
      cpe_pkg::S_PREV_CAP: state_next = cpe_pkg::S_SEL;
      cpe_pkg::S_SEL: begin
        if (rd_p1 < size) state_next = cpe_pkg::S_REP_CAP;
        else if (full) state_next = cpe_pkg::S_DONE;
        else state_next = cpe_pkg::S_PROB;
      end
      cpe_pkg::S_REP_CAP: begin
        state_next = (rd_p1 == size - 1'b1) ? cpe_pkg::S_PROB : cpe_pkg::S_DONE;
      end
      cpe_pkg::S_PROB: begin
        if (!div_busy || kind == cpe_pkg::KIND_WEIGHTED) state_next = cpe_pkg::S_MUL;
      end
      cpe_pkg::S_MUL:     state_next = cpe_pkg::S_WR;
      cpe_pkg::S_WR:      state_next = cpe_pkg::S_DONE;
      cpe_pkg::S_POP_RD: begin
        state_next = (size == '0) ? cpe_pkg::S_DONE : cpe_pkg::S_POP_CHK;
      end
      cpe_pkg::S_POP_CHK: begin
        state_next = pop_adv ? cpe_pkg::S_DONE : cpe_pkg::S_POP_RD;
      end
      cpe_pkg::S_FIN_RD:  state_next = cpe_pkg::S_FIN_CAP;
      cpe_pkg::S_FIN_CAP: state_next = cpe_pkg::S_DONE;
      cpe_pkg::S_DONE: begin
        if (out_free) state_next = cpe_pkg::S_IDLE;
      end
      default: state_next = cpe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = widx;
    ram_wdata = '{opt: idx, cnt: keep_cnt, prob: prod};
    div_start = 1'b0;
    case (state)
      cpe_pkg::S_DECODE:  div_start = kind == cpe_pkg::KIND_UNIFORM;
      cpe_pkg::S_PREV_RD: ram_raddr = cpe_pkg::IDX_W'(rd_p1 - 1'b1);
      cpe_pkg::S_SEL:     ram_raddr = rd_p1[cpe_pkg::IDX_W-1:0];
      cpe_pkg::S_WR:      ram_we = 1'b1;
      cpe_pkg::S_POP_RD:  ram_raddr = top_idx;
      cpe_pkg::S_POP_CHK: begin
        ram_we    = pop_adv;
        ram_waddr = top_idx;
        ram_wdata = '{opt: rd.opt + 1'b1, cnt: rd.cnt, prob: rd.prob};
      end
      cpe_pkg::S_FIN_RD:  ram_raddr = top_idx;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cpe_pkg::S_IDLE;
      size       <= '0;
      rd_p1      <= '0;
      first_flag <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      // A new result may replace one that leaves in the same cycle.
      if (state == cpe_pkg::S_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        cpe_pkg::S_DECODE: begin
          case (kind)
            cpe_pkg::KIND_BEGIN: first_flag <= 1'b1;
            cpe_pkg::KIND_NEXT: begin
              rd_p1 <= '0;
              if (first_flag) first_flag <= 1'b0;
            end
            default: ;
          endcase
        end
        cpe_pkg::S_SEL: begin
          // A new choice pushes a fresh entry at the top of the stack.
          if (!(rd_p1 < size) && !full) begin
            size  <= size + 1'b1;
            rd_p1 <= size + 1'b1;
          end
        end
        cpe_pkg::S_REP_CAP: rd_p1 <= rd_p1 + 1'b1;
        cpe_pkg::S_POP_CHK: begin
          if (!pop_adv) size <= size - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cpe_pkg::S_IDLE: begin
        if (s_tvalid) begin
          kind <= cpe_pkg::kind_t'(s_tuser);
          n    <= s_tdata[cpe_pkg::CNT_W-1:0];
          for (int i = 0; i < cpe_pkg::WEIGHTED_MAX; i++) begin
            probs[i] <= s_tdata[cpe_pkg::CNT_W + i*cpe_pkg::PROB_W +: cpe_pkg::PROB_W];
          end
          r_chosen <= '0;
          r_avail  <= 1'b0;
          r_prob   <= '0;
          r_status <= cpe_pkg::ST_OK;
        end
      end
      cpe_pkg::S_DECODE: begin
        prev <= cpe_pkg::PROB_ONE;
        case (kind)
          cpe_pkg::KIND_NEXT: begin
            if (rd_p1 != size) r_status <= cpe_pkg::ST_MISMATCH;
            if (first_flag) r_avail <= 1'b1;
          end
          cpe_pkg::KIND_UNIFORM, cpe_pkg::KIND_WEIGHTED: begin
            if (bad_count) r_status <= cpe_pkg::ST_BAD_COUNT;
          end
          cpe_pkg::KIND_FINISH: begin
            if (size == '0) r_prob <= cpe_pkg::PROB_ONE;
          end
          default: ;
        endcase
      end
      cpe_pkg::S_PREV_CAP: prev <= rd.prob;
      cpe_pkg::S_SEL: begin
        if (!(rd_p1 < size)) begin
          if (full) begin
            r_status <= cpe_pkg::ST_OVERFLOW;
          end else begin
            idx      <= '0;
            keep_cnt <= n;
            widx     <= size[cpe_pkg::IDX_W-1:0];
          end
        end
      end
      cpe_pkg::S_REP_CAP: begin
        idx      <= rd.opt;
        keep_cnt <= rd.cnt;
        widx     <= rd_p1[cpe_pkg::IDX_W-1:0];
        r_chosen <= rd.opt;
      end
      cpe_pkg::S_PROB: factor <= (kind == cpe_pkg::KIND_WEIGHTED) ? wfactor : div_q;
      cpe_pkg::S_MUL: begin
        prod <= (shifted > cpe_pkg::MUL_SH_W'(cpe_pkg::PROB_ONE)) ? cpe_pkg::PROB_ONE :
                cpe_pkg::PROB_W'(shifted);
      end
      cpe_pkg::S_POP_CHK: begin
        if (pop_adv) r_avail <= 1'b1;
      end
      cpe_pkg::S_FIN_CAP: r_prob <= rd.prob;
      cpe_pkg::S_DONE: begin
        if (out_free) m_tdata <= {4'b0, r_status, r_prob, r_avail, r_chosen};
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_replay_within_stack: assert property (@(posedge clk) disable iff (rst)
    rd_p1 <= size)
    else $error("replay depth points above the stack top");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    size <= cpe_pkg::SIZE_W'(cpe_pkg::STACK_DEPTH))
    else $error("stack size beyond its depth");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again before the item finished");

  a_write_inside_stack: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> cpe_pkg::SIZE_W'(ram_waddr) < size)
    else $error("stack write outside the live entries");
`endif

endmodule

>>> hdl/cpe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the choice stack entries of the enumerator.
module cpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/cpe_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Uses widths from cpe_pkg; forms the 1/n probability of a uniform choice.
module cpe_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cpe_pkg::PROB_W-1:0] dividend,
  input  logic [cpe_pkg::CNT_W-1:0]  divisor,
  output logic                       busy,
  output logic [cpe_pkg::PROB_W-1:0] quotient
);

  logic [cpe_pkg::CNT_W-1:0]      rem;
  logic [cpe_pkg::CNT_W-1:0]      dsr;
  logic [cpe_pkg::PROB_W-1:0]     quo;
  logic [cpe_pkg::DIV_STEP_W-1:0] steps;
  logic [cpe_pkg::CNT_W:0]        trial;
  logic                           fits;

  // The dividend shifts out of the top of quo while quotient bits enter below.
  assign trial    = {rem, quo[cpe_pkg::PROB_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= cpe_pkg::DIV_STEP_W'(cpe_pkg::PROB_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      busy  <= steps != cpe_pkg::DIV_STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? cpe_pkg::CNT_W'(trial - {1'b0, dsr}) : cpe_pkg::CNT_W'(trial);
      quo <= {quo[cpe_pkg::PROB_W-2:0], fits};
    end
  end

endmodule

>>> verif/choice_path_enumerator_tb.sv
// Self-checking testbench for choice_path_enumerator: drives choice items on the stream input and
// checks each result transfer against a scoreboard that keeps its own copy of the choice stack.
// Depends on cpe_pkg and the choice_path_enumerator RTL only.
import cpe_pkg::*;

typedef struct packed {
  logic [3:0]          pad;
  logic [STATUS_W-1:0] status;
  logic [PROB_W-1:0]   prob;
  logic                avail;
  logic [OPT_W-1:0]    opt;
} step_result_t;

class path_scoreboard;
  logic [OPT_W-1:0]  opt_mem  [STACK_DEPTH];
  logic [CNT_W-1:0]  cnt_mem  [STACK_DEPTH];
  logic [PROB_W-1:0] prob_mem [STACK_DEPTH];
  int  depth;
  int  replay;
  bit  first_path;
  step_result_t pending_q[$];
  int  errors;
  int  paths_found;
  int  kind_seen[8];
  int  status_seen[4];

  function new();
    depth = 0;
    replay = -1;
    first_path = 1'b0;
    errors = 0;
    paths_found = 0;
  endfunction

  function logic [PROB_W-1:0] sat(longint unsigned v);
    return (v > PROB_ONE) ? PROB_ONE : v[PROB_W-1:0];
  endfunction

  // Fixed-point product with 16 fraction bits, truncated and saturated at one.
  function logic [PROB_W-1:0] scale(logic [PROB_W-1:0] a, logic [PROB_W-1:0] b);
    longint unsigned p;
    p = a;
    p = (p * b) >> PROB_FRAC;
    return sat(p);
  endfunction

  function logic [PROB_W-1:0] option_prob(bit weighted, int n, int idx,
                                          logic [WEIGHTED_MAX*PROB_W-1:0] probs);
    if (!weighted) return PROB_W'(PROB_ONE / n);
    if (idx >= n || idx >= WEIGHTED_MAX) return '0;
    return sat(probs[idx*PROB_W +: PROB_W]);
  endfunction

  function step_result_t choose(bit weighted, int n, logic [WEIGHTED_MAX*PROB_W-1:0] probs);
    step_result_t r;
    logic [PROB_W-1:0] prev;
    int d;
    r = '0;
    if (n == 0 || n > (weighted ? WEIGHTED_MAX : MAX_OPTIONS)) begin
      r.status = ST_BAD_COUNT;
      return r;
    end
    prev = PROB_ONE;
    if (replay >= 0 && replay < depth) prev = prob_mem[replay];
    d = replay + 1;
    if (d < depth) begin
      // Replaying a known choice; only the deepest one gets its probability refreshed.
      if (d == depth - 1) prob_mem[d] = scale(option_prob(weighted, n, opt_mem[d], probs), prev);
      replay = d;
      r.opt = opt_mem[d];
      return r;
    end
    if (depth >= STACK_DEPTH) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    opt_mem[depth] = '0;
    cnt_mem[depth] = CNT_W'(n);
    prob_mem[depth] = scale(option_prob(weighted, n, 0, probs), prev);
    replay = depth;
    depth++;
    return r;
  endfunction

  function bit advance();
    replay = -1;
    if (first_path) begin
      first_path = 1'b0;
      return 1'b1;
    end
    while (depth > 0) begin
      if (int'(cnt_mem[depth-1]) > int'(opt_mem[depth-1]) + 1) begin
        opt_mem[depth-1]++;
        return 1'b1;
      end
      depth--;
    end
    return 1'b0;
  endfunction

  // Called for every accepted input transfer; returns and queues the predicted result.
  function step_result_t note(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] data);
    step_result_t r;
    int n;
    logic [WEIGHTED_MAX*PROB_W-1:0] probs;
    r = '0;
    n = int'(data[CNT_W-1:0]);
    probs = data[CNT_W +: WEIGHTED_MAX*PROB_W];
    case (kind)
      KIND_BEGIN: first_path = 1'b1;
      KIND_NEXT: begin
        if (replay != depth - 1) r.status = ST_MISMATCH;
        r.avail = advance();
        paths_found += int'(r.avail);
      end
      KIND_UNIFORM:  r = choose(1'b0, n, probs);
      KIND_WEIGHTED: r = choose(1'b1, n, probs);
      KIND_FINISH:   r.prob = (depth > 0) ? prob_mem[depth-1] : PROB_ONE;
      default: ;
    endcase
    kind_seen[kind]++;
    status_seen[r.status]++;
    pending_q = {pending_q, r};
    return r;
  endfunction

  function void check(logic [OUT_DATA_W-1:0] data);
    step_result_t got;
    step_result_t want;
    got = data;
    if (pending_q.size() == 0) begin
      errors++;
      $display("%0t: result transfer %h with nothing expected", $time, data);
      return;
    end
    want = pending_q.pop_front();
    if (got.opt !== want.opt) begin
      errors++;
      $display("%0t: chosen_option expected %0d, actual %0d", $time, want.opt, got.opt);
    end
    if (got.avail !== want.avail) begin
      errors++;
      $display("%0t: path_available expected %0d, actual %0d", $time, want.avail, got.avail);
    end
    if (got.prob !== want.prob) begin
      errors++;
      $display("%0t: step_probability expected %0d, actual %0d", $time, want.prob, got.prob);
    end
    if (got.status !== want.status) begin
      errors++;
      $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
    end
  endfunction
endclass

module choice_path_enumerator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 975;
  localparam int CALM_AFTER  = 870;
  localparam int HOLD_AT     = 400;
  localparam int PAUSE_AT    = 650;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_LIMIT = 20000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [KIND_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  path_scoreboard sb;
  int items_sent = 0;
  bit hold_req = 1'b0;

  choice_path_enumerator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("%0t: run did not complete in time", $time);
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [WEIGHTED_MAX*PROB_W-1:0] rand_probs();
    logic [WEIGHTED_MAX*PROB_W-1:0] v;
    for (int i = 0; i < WEIGHTED_MAX; i++) begin
      case ($urandom_range(0, 5))
        0:       v[i*PROB_W +: PROB_W] = '0;
        1:       v[i*PROB_W +: PROB_W] = PROB_ONE;
        2:       v[i*PROB_W +: PROB_W] = PROB_W'($urandom_range(0, 2**PROB_W - 1));
        default: v[i*PROB_W +: PROB_W] = PROB_W'($urandom_range(0, PROB_ONE));
      endcase
    end
    return v;
  endfunction

  // Offers one item and returns once the transfer has happened.
  task automatic send_item(input logic [KIND_W-1:0] kind, input int n,
                           input logic [WEIGHTED_MAX*PROB_W-1:0] probs,
                           output step_result_t predicted);
    logic [IN_DATA_W-1:0] data;
    data = '0;
    data[CNT_W-1:0] = CNT_W'(n);
    data[CNT_W +: WEIGHTED_MAX*PROB_W] = probs;
    if (items_sent < CALM_AFTER && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = sb.note(kind, data);
    items_sent++;
    if (items_sent == HOLD_AT) hold_req = 1'b1;
  endtask

  // Result side: random stalls, plus one long hold that backs the block up.
  initial begin
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (items_sent < CALM_AFTER && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata);
  end

  initial begin
    step_result_t r;
    logic [WEIGHTED_MAX*PROB_W-1:0] probs;
    bit prog_weighted [STACK_DEPTH+3];
    int prog_count [STACK_DEPTH+3];
    int len;
    int cap;
    int paths;
    int w;
    bit deep;
    bit done;
    bit paused;

    sb = new();
    paused = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= '0;
    s_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: unused kinds, empty stack, bad counts, widest choices and replays.
    for (int k = KIND_FINISH + 1; k < 8; k++) send_item(KIND_W'(k), 2**CNT_W - 1, '1, r);
    send_item(KIND_FINISH, 0, '0, r);
    send_item(KIND_NEXT, 0, '0, r);
    send_item(KIND_BEGIN, 0, '0, r);
    send_item(KIND_NEXT, 0, '0, r);
    send_item(KIND_UNIFORM, 0, '0, r);
    send_item(KIND_UNIFORM, MAX_OPTIONS + 1, '0, r);
    send_item(KIND_UNIFORM, 2**CNT_W - 1, '0, r);
    send_item(KIND_WEIGHTED, 0, '0, r);
    send_item(KIND_WEIGHTED, WEIGHTED_MAX + 1, '0, r);
    send_item(KIND_UNIFORM, MAX_OPTIONS, '0, r);
    // Option 0 is above one and must saturate.
    probs = {17'd65535, 17'd0, 17'd1, 17'd32768, 17'd98304, 17'd65536, 17'd21845, 17'h1FFFF};
    send_item(KIND_WEIGHTED, WEIGHTED_MAX, probs, r);
    send_item(KIND_FINISH, 0, '0, r);
    send_item(KIND_NEXT, 0, '0, r);
    send_item(KIND_UNIFORM, MAX_OPTIONS, '0, r);
    send_item(KIND_WEIGHTED, WEIGHTED_MAX, probs, r);
    send_item(KIND_FINISH, 0, '0, r);
    send_item(KIND_NEXT, 0, '0, r);
    send_item(KIND_UNIFORM, MAX_OPTIONS, '0, r);
    // Next path with only part of the stack replayed is a depth mismatch.
    send_item(KIND_NEXT, 0, '0, r);
    send_item(KIND_UNIFORM, MAX_OPTIONS, '0, r);
    // Stored option 3 replayed as a two-way weighted choice has probability zero.
    send_item(KIND_WEIGHTED, 2, probs, r);
    send_item(KIND_FINISH, 0, '0, r);

    // Random part: mostly enumerations of a random choice program up to a path cap, some noise.
    while (items_sent < TOTAL_ITEMS) begin
      if (!paused && items_sent >= PAUSE_AT) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_q.size() != 0);
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(2, 8))
          send_item(KIND_W'($urandom_range(0, 7)), $urandom_range(0, 2**CNT_W - 1),
                    rand_probs(), r);
      end else begin
        deep = ($urandom_range(0, 11) == 0);
        len = deep ? $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2) : $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          prog_weighted[i] = ($urandom_range(0, 2) == 0);
          if (deep)
            prog_count[i] = ($urandom_range(0, 4) == 0) ? 2 : 1;
          else if (prog_weighted[i])
            prog_count[i] = $urandom_range(1, WEIGHTED_MAX);
          else if ($urandom_range(0, 9) == 0)
            prog_count[i] = $urandom_range(1, MAX_OPTIONS);
          else
            prog_count[i] = $urandom_range(1, 4);
          if ($urandom_range(0, 39) == 0)
            prog_count[i] = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_OPTIONS + 1, 2**CNT_W - 1);
        end
        cap = deep ? 3 : $urandom_range(4, 16);
        send_item(KIND_BEGIN, 0, '0, r);
        paths = 0;
        done = 1'b0;
        while (!done) begin
          send_item(KIND_NEXT, 0, '0, r);
          if (!r.avail || paths >= cap || items_sent >= TOTAL_ITEMS) begin
            done = 1'b1;
          end else begin
            for (int i = 0; i < len; i++) begin
              if ($urandom_range(0, 29) == 0) break;
              send_item(prog_weighted[i] ? KIND_WEIGHTED : KIND_UNIFORM, prog_count[i],
                        rand_probs(), r);
            end
            if ($urandom_range(0, 29) == 0) send_item(KIND_UNIFORM, $urandom_range(1, 4), '0, r);
            if ($urandom_range(0, 29) != 0) send_item(KIND_FINISH, 0, '0, r);
            paths++;
          end
        end
      end
    end

    s_tvalid <= 1'b0;
    w = 0;
    do begin
      @(posedge clk);
      w++;
    end while (sb.pending_q.size() != 0 && w < DRAIN_LIMIT);
    repeat (40) @(posedge clk);

    $display("Ran %0d items: %0d chooses, %0d next-path requests (%0d gave a path), %0d finishes.",
             items_sent, sb.kind_seen[KIND_UNIFORM] + sb.kind_seen[KIND_WEIGHTED],
             sb.kind_seen[KIND_NEXT], sb.paths_found, sb.kind_seen[KIND_FINISH]);
    $display("Statuses seen: %0d ok, %0d overflow, %0d depth mismatch, %0d bad count.",
             sb.status_seen[ST_OK], sb.status_seen[ST_OVERFLOW], sb.status_seen[ST_MISMATCH],
             sb.status_seen[ST_BAD_COUNT]);
    if (sb.pending_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending_q.size());
    end
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
